>>> rtl/ecefl_pkg.sv
// Shared types, constants and small functions of the ECEF / local frame transform.
// Used by the setup sequencer, the point datapath, the top level and the checker.
// No dependencies.
package ecefl_pkg;

    // Coordinate and angle resolution.
    localparam int COORD_BITS = 40;
    localparam int ANGLE_BITS = 32;
    localparam int ANGLE_DROP = (ANGLE_BITS < 32) ? (32 - ANGLE_BITS) : 0;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << ANGLE_DROP) - 32'd1);

    // Internal widths of the reference frame.
    localparam int CFG_W  = 32;
    localparam int COEF_W = 32;
    localparam int REF_W  = 36;

    // WGS84 and CORDIC constants.
    localparam logic [32:0] SEMI_MAJOR_MM = 33'd6378137000;
    localparam logic signed [31:0] ECC2_Q36 = 32'sd460034290;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
    localparam int CORDIC_STEPS = 30;

    typedef enum logic [1:0] {
        CMD_ECEF_TO_ENU = 2'd0,
        CMD_ENU_TO_ECEF = 2'd1,
        CMD_ECEF_TO_NED = 2'd2,
        CMD_NED_TO_ECEF = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        CFG_REF_LATITUDE  = 2'd0,
        CFG_REF_LONGITUDE = 2'd1,
        CFG_REF_HEIGHT    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        command_t                      command;
        logic signed [COORD_BITS-1:0]  coord_first;
        logic signed [COORD_BITS-1:0]  coord_second;
        logic signed [COORD_BITS-1:0]  coord_third;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  result_first;
        logic signed [COORD_BITS-1:0]  result_second;
        logic signed [COORD_BITS-1:0]  result_third;
        logic                          saturated;
    } result_t;

    // Reference position in ECEF and the ENU rotation, row major, Q30.
    typedef struct packed {
        logic [2:0][REF_W-1:0]   ref_pos;
        logic [8:0][COEF_W-1:0]  mtx;
    } frame_t;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
        logic signed [33:0] val;
        case (idx)
            5'd0:  val = 34'sd536870912;
            5'd1:  val = 34'sd316933406;
            5'd2:  val = 34'sd167458907;
            5'd3:  val = 34'sd85004756;
            5'd4:  val = 34'sd42667331;
            5'd5:  val = 34'sd21354465;
            5'd6:  val = 34'sd10679838;
            5'd7:  val = 34'sd5340245;
            5'd8:  val = 34'sd2670163;
            5'd9:  val = 34'sd1335087;
            5'd10: val = 34'sd667544;
            5'd11: val = 34'sd333772;
            5'd12: val = 34'sd166886;
            5'd13: val = 34'sd83443;
            5'd14: val = 34'sd41722;
            5'd15: val = 34'sd20861;
            5'd16: val = 34'sd10430;
            5'd17: val = 34'sd5215;
            5'd18: val = 34'sd2608;
            5'd19: val = 34'sd1304;
            5'd20: val = 34'sd652;
            5'd21: val = 34'sd326;
            5'd22: val = 34'sd163;
            5'd23: val = 34'sd81;
            5'd24: val = 34'sd41;
            5'd25: val = 34'sd20;
            5'd26: val = 34'sd10;
            5'd27: val = 34'sd5;
            5'd28: val = 34'sd3;
            5'd29: val = 34'sd1;
            default: val = 34'sd0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/ecefl_setup.sv
// Reference frame sequencer: CORDIC sine/cosine, prime vertical radius through a
// bit-serial square root and divider, and the reference ECEF position and rotation.
// Depends on ecefl_pkg.
module ecefl_setup (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               restart,
    input  logic [ecefl_pkg::CFG_W-1:0]        ref_latitude,
    input  logic [ecefl_pkg::CFG_W-1:0]        ref_longitude,
    input  logic [ecefl_pkg::CFG_W-1:0]        ref_height,
    output ecefl_pkg::frame_t                  frame,
    output logic                               busy
);

    typedef enum logic [5:0] {
        ST_START  = 6'b000001,
        ST_CORDIC = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_SQRT   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_READY  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        OP_S2, OP_E2S2, OP_P, OP_REF_X, OP_REF_Y, OP_E2N, OP_REF_Z,
        OP_M10, OP_M11, OP_M20, OP_M21
    } op_t;

    localparam int CW = 34;
    localparam int MA_W = 36;
    localparam int MB_W = 32;
    localparam int PR_W = MA_W + MB_W;
    localparam int REF_W_L = ecefl_pkg::REF_W;
    localparam logic [5:0] CORDIC_LAST = 6'(ecefl_pkg::CORDIC_STEPS);
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd62;
    localparam logic signed [PR_W-1:0] RND30 = PR_W'(1) <<< 29;
    localparam logic signed [PR_W-1:0] RND36 = PR_W'(1) <<< 35;

    state_t state_reg;
    op_t    op_reg;
    logic [5:0] step_reg;
    logic lon_pass_reg;
    logic phase_reg;

    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic flip_reg;
    logic signed [31:0] sl_reg, cl_reg, so_reg, co_reg;
    logic signed [31:0] s2_reg, e2n_reg;
    logic signed [MA_W-1:0] p_reg;
    logic signed [REF_W_L-1:0] ref_reg [3];
    logic signed [31:0] m10_reg, m11_reg, m20_reg, m21_reg;
    logic signed [PR_W-1:0] prod_reg;
    logic [63:0] sq_v_reg, sq_r_reg, sq_b_reg;
    logic [30:0] rem_reg;
    logic [62:0] dv_reg, q_reg;

    // Angle folding and CORDIC step.
    logic [31:0] angle_sel;
    logic signed [CW-1:0] z_init, z_fold;
    logic fold;
    logic signed [CW-1:0] dx, dy, atan_val, cx_next, cy_next, cz_next;
    logic signed [CW-1:0] x_fin, y_fin;
    logic signed [31:0] cos_fin, sin_fin;

    // Shared multiplier.
    logic signed [MA_W-1:0] mul_a, n_val, h_val;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PR_W-1:0] rsum30, rsum36;
    logic signed [37:0] rnd30;
    logic signed [31:0] rnd36;

    // Square root and divider.
    logic [63:0] sq_t, sq_v_next, sq_r_next;
    logic sq_ge;
    logic [31:0] rem_sh;
    logic div_ge;
    logic [30:0] rem_next;
    logic [62:0] dividend;

    function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [31:0] res;
        if (v > ecefl_pkg::ONE_Q30) res = 32'(ecefl_pkg::ONE_Q30);
        else if (v < -ecefl_pkg::ONE_Q30) res = 32'(-ecefl_pkg::ONE_Q30);
        else res = 32'(v);
        return res;
    endfunction

    always_comb
    begin
        angle_sel = (lon_pass_reg ? ref_longitude : ref_latitude) & ecefl_pkg::ANGLE_MASK;
        z_init = CW'($signed(angle_sel));
        fold = 1'b0;
        z_fold = z_init;
        if (z_init > ecefl_pkg::QUARTER_TURN)
        begin
            z_fold = z_init - ecefl_pkg::HALF_TURN;
            fold = 1'b1;
        end
        else if (z_init < -ecefl_pkg::QUARTER_TURN)
        begin
            z_fold = z_init + ecefl_pkg::HALF_TURN;
            fold = 1'b1;
        end

        dx = cy_reg >>> step_reg;
        dy = cx_reg >>> step_reg;
        atan_val = ecefl_pkg::atan_turn(step_reg[4:0]);
        if (cz_reg >= 0)
        begin
            cx_next = cx_reg - dx;
            cy_next = cy_reg + dy;
            cz_next = cz_reg - atan_val;
        end
        else
        begin
            cx_next = cx_reg + dx;
            cy_next = cy_reg - dy;
            cz_next = cz_reg + atan_val;
        end
        x_fin = flip_reg ? -cx_reg : cx_reg;
        y_fin = flip_reg ? -cy_reg : cy_reg;
        cos_fin = clamp_unit(x_fin);
        sin_fin = clamp_unit(y_fin);
    end

    always_comb
    begin
        n_val = $signed({1'b0, q_reg[MA_W-2:0]});
        h_val = MA_W'($signed(ref_height));
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_S2:    begin mul_a = MA_W'(sl_reg); mul_b = sl_reg; end
            OP_E2S2:  begin mul_a = MA_W'(s2_reg); mul_b = ecefl_pkg::ECC2_Q36; end
            OP_P:     begin mul_a = n_val + h_val; mul_b = cl_reg; end
            OP_REF_X: begin mul_a = p_reg; mul_b = co_reg; end
            OP_REF_Y: begin mul_a = p_reg; mul_b = so_reg; end
            OP_E2N:   begin mul_a = n_val; mul_b = ecefl_pkg::ECC2_Q36; end
            OP_REF_Z: begin mul_a = n_val - MA_W'(e2n_reg) + h_val; mul_b = sl_reg; end
            OP_M10:   begin mul_a = MA_W'(co_reg); mul_b = sl_reg; end
            OP_M11:   begin mul_a = MA_W'(so_reg); mul_b = sl_reg; end
            OP_M20:   begin mul_a = MA_W'(co_reg); mul_b = cl_reg; end
            OP_M21:   begin mul_a = MA_W'(so_reg); mul_b = cl_reg; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
        rsum30 = prod_reg + RND30;
        rsum36 = prod_reg + RND36;
        rnd30 = $signed(rsum30[PR_W-1:30]);
        rnd36 = $signed(rsum36[67:36]);
    end

    always_comb
    begin
        sq_t = sq_r_reg + sq_b_reg;
        sq_ge = (sq_v_reg >= sq_t);
        sq_v_next = sq_ge ? (sq_v_reg - sq_t) : sq_v_reg;
        sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_b_reg) : (sq_r_reg >> 1);
        dividend = 63'({ecefl_pkg::SEMI_MAJOR_MM, 30'd0}) + 63'(sq_r_next >> 1);
        rem_sh = {1'b0, rem_reg} << 1 | 32'(dv_reg[62]);
        div_ge = (rem_sh >= sq_r_reg[31:0]);
        rem_next = div_ge ? 31'(rem_sh - sq_r_reg[31:0]) : rem_sh[30:0];
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            op_reg <= OP_S2;
            step_reg <= '0;
            lon_pass_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (restart)
        begin
            state_reg <= ST_START;
            lon_pass_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_START:
                begin
                    state_reg <= ST_CORDIC;
                    step_reg <= '0;
                end
                ST_CORDIC:
                begin
                    if (step_reg == CORDIC_LAST)
                    begin
                        if (!lon_pass_reg)
                        begin
                            lon_pass_reg <= 1'b1;
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                            op_reg <= OP_S2;
                            phase_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_MUL:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        if (op_reg == OP_M21)
                        begin
                            state_reg <= ST_READY;
                        end
                        else
                        begin
                            op_reg <= op_t'(op_reg + 4'd1);
                            if (op_reg == OP_E2S2)
                            begin
                                state_reg <= ST_SQRT;
                                step_reg <= '0;
                            end
                        end
                    end
                end
                ST_SQRT:
                begin
                    if (step_reg == SQRT_LAST)
                    begin
                        state_reg <= ST_DIV;
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == DIV_LAST)
                    begin
                        state_reg <= ST_MUL;
                        phase_reg <= 1'b0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_READY:
                begin
                    state_reg <= ST_READY;
                end
                default:
                begin
                    state_reg <= ST_START;
                end
            endcase
        end
    end

    // Sequencer data registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_START:
            begin
                cx_reg <= ecefl_pkg::GAIN_Q30;
                cy_reg <= '0;
                cz_reg <= z_fold;
                flip_reg <= fold;
            end
            ST_CORDIC:
            begin
                if (step_reg == CORDIC_LAST)
                begin
                    if (!lon_pass_reg)
                    begin
                        sl_reg <= sin_fin;
                        cl_reg <= cos_fin;
                    end
                    else
                    begin
                        so_reg <= sin_fin;
                        co_reg <= cos_fin;
                    end
                end
                else
                begin
                    cx_reg <= cx_next;
                    cy_reg <= cy_next;
                    cz_reg <= cz_next;
                end
            end
            ST_MUL:
            begin
                if (!phase_reg)
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else
                begin
                    case (op_reg)
                        OP_S2:    s2_reg <= 32'(rnd30);
                        OP_E2S2:
                        begin
                            sq_v_reg <= 64'(32'(ecefl_pkg::ONE_Q30) - rnd36) << 30;
                            sq_r_reg <= '0;
                            sq_b_reg <= 64'd1 << 62;
                        end
                        OP_P:     p_reg <= MA_W'(rnd30);
                        OP_REF_X: ref_reg[0] <= REF_W_L'(rnd30);
                        OP_REF_Y: ref_reg[1] <= REF_W_L'(rnd30);
                        OP_E2N:   e2n_reg <= rnd36;
                        OP_REF_Z: ref_reg[2] <= REF_W_L'(rnd30);
                        OP_M10:   m10_reg <= -32'(rnd30);
                        OP_M11:   m11_reg <= -32'(rnd30);
                        OP_M20:   m20_reg <= 32'(rnd30);
                        OP_M21:   m21_reg <= 32'(rnd30);
                        default:  s2_reg <= s2_reg;
                    endcase
                end
            end
            ST_SQRT:
            begin
                sq_v_reg <= sq_v_next;
                sq_r_reg <= sq_r_next;
                sq_b_reg <= sq_b_reg >> 2;
                if (step_reg == SQRT_LAST)
                begin
                    dv_reg <= dividend;
                    rem_reg <= '0;
                    q_reg <= '0;
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                dv_reg <= dv_reg << 1;
                q_reg <= {q_reg[61:0], div_ge};
            end
            ST_READY:
            begin
                prod_reg <= prod_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != ST_READY);
        frame.ref_pos[0] = ref_reg[0];
        frame.ref_pos[1] = ref_reg[1];
        frame.ref_pos[2] = ref_reg[2];
        frame.mtx[0] = -so_reg;
        frame.mtx[1] = co_reg;
        frame.mtx[2] = '0;
        frame.mtx[3] = m10_reg;
        frame.mtx[4] = m11_reg;
        frame.mtx[5] = cl_reg;
        frame.mtx[6] = m20_reg;
        frame.mtx[7] = m21_reg;
        frame.mtx[8] = sl_reg;
    end

endmodule

>>> rtl/ecefl_datapath.sv
// Five-stage point pipeline: offset or reorder, split partial products, row sums,
// rounding, then reference add, NED reorder and saturation into the output register.
// Depends on ecefl_pkg.
module ecefl_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                busy,
    input  ecefl_pkg::frame_t   frame,
    input  logic                point_valid,
    output logic                point_stall,
    input  ecefl_pkg::point_t   point,
    output logic                result_valid,
    input  logic                result_stall,
    output ecefl_pkg::result_t  result
);

    localparam int CB = ecefl_pkg::COORD_BITS;
    localparam int CF = ecefl_pkg::COEF_W;
    localparam int VEC_W = CB + 1;
    localparam int LO_BITS = 21;
    localparam int HI_W = VEC_W - LO_BITS;
    localparam int PH_W = HI_W + CF;
    localparam int PL_W = LO_BITS + 1 + CF;
    localparam int SH_W = PH_W + 2;
    localparam int SL_W = PL_W + 2;
    localparam int ACC_W = VEC_W + 34;
    localparam int DOT_W = ACC_W - 30;
    localparam int RES_W = DOT_W + 1;
    localparam logic signed [ACC_W-1:0] RND30 = ACC_W'(1) <<< 29;
    localparam logic signed [RES_W-1:0] HI_LIM = RES_W'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] LO_LIM = -HI_LIM - RES_W'(1);

    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, result_valid_reg;
    ecefl_pkg::command_t cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    logic signed [VEC_W-1:0] vec1_reg [3];
    logic signed [PH_W-1:0] ph2_reg [3][3];
    logic signed [PL_W-1:0] pl2_reg [3][3];
    logic signed [SH_W-1:0] sh3_reg [3];
    logic signed [SL_W-1:0] sl3_reg [3];
    logic signed [DOT_W-1:0] dot4_reg [3];
    ecefl_pkg::result_t result_reg;

    logic signed [VEC_W-1:0] pt [3];
    logic signed [VEC_W-1:0] rf [3];
    logic signed [VEC_W-1:0] vec1_next [3];
    logic signed [PH_W-1:0] ph2_next [3][3];
    logic signed [PL_W-1:0] pl2_next [3][3];
    logic signed [SH_W-1:0] sh3_next [3];
    logic signed [SL_W-1:0] sl3_next [3];
    logic signed [DOT_W-1:0] dot4_next [3];
    logic signed [ACC_W-1:0] acc [3];
    logic signed [RES_W-1:0] res [3];
    logic signed [RES_W-1:0] clip [3];
    logic sat;
    logic inverse2;
    ecefl_pkg::result_t result_next;

    // Each stage loads when it is empty or the stage after it moves.
    always_comb
    begin
        en5 = !result_valid_reg || !result_stall;
        en4 = !v4_reg || en5;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
        point_stall = busy || !en1;
    end

    // Stage one: offset from the reference or reorder a local vector.
    always_comb
    begin
        pt[0] = VEC_W'(point.coord_first);
        pt[1] = VEC_W'(point.coord_second);
        pt[2] = VEC_W'(point.coord_third);
        for (int k = 0; k < 3; k++)
        begin
            rf[k] = VEC_W'($signed(frame.ref_pos[k]));
        end
        unique case (point.command) inside
            ecefl_pkg::CMD_ECEF_TO_ENU, ecefl_pkg::CMD_ECEF_TO_NED:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vec1_next[k] = pt[k] - rf[k];
                end
            end
            ecefl_pkg::CMD_NED_TO_ECEF:
            begin
                vec1_next[0] = pt[1];
                vec1_next[1] = pt[0];
                vec1_next[2] = -pt[2];
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vec1_next[k] = pt[k];
                end
            end
        endcase
    end

    // Stage two: each 41-bit component splits into a signed high part and an
    // unsigned low part, so no product is wider than 22 by 32 bits.
    always_comb
    begin
        inverse2 = cmd1_reg[0];
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [CF-1:0] c;
                logic signed [HI_W-1:0] hi;
                logic signed [LO_BITS:0] lo;
                c = inverse2 ? $signed(frame.mtx[3*k+r]) : $signed(frame.mtx[3*r+k]);
                hi = vec1_reg[k][VEC_W-1:LO_BITS];
                lo = $signed({1'b0, vec1_reg[k][LO_BITS-1:0]});
                ph2_next[r][k] = PH_W'(hi) * PH_W'(c);
                pl2_next[r][k] = PL_W'(lo) * PL_W'(c);
            end
        end
    end

    // Stage three and four: row sums, then one rounding of the exact total.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sh3_next[r] = SH_W'(ph2_reg[r][0]) + SH_W'(ph2_reg[r][1]) + SH_W'(ph2_reg[r][2]);
            sl3_next[r] = SL_W'(pl2_reg[r][0]) + SL_W'(pl2_reg[r][1]) + SL_W'(pl2_reg[r][2]);
            acc[r] = (ACC_W'(sh3_reg[r]) <<< LO_BITS) + ACC_W'(sl3_reg[r]) + RND30;
            dot4_next[r] = $signed(acc[r][ACC_W-1:30]);
        end
    end

    // Stage five: reference add or NED reorder, then saturation.
    always_comb
    begin
        unique case (cmd4_reg) inside
            ecefl_pkg::CMD_ENU_TO_ECEF, ecefl_pkg::CMD_NED_TO_ECEF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    res[k] = RES_W'($signed(frame.ref_pos[k])) + RES_W'(dot4_reg[k]);
                end
            end
            ecefl_pkg::CMD_ECEF_TO_NED:
            begin
                res[0] = RES_W'(dot4_reg[1]);
                res[1] = RES_W'(dot4_reg[0]);
                res[2] = -RES_W'(dot4_reg[2]);
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    res[k] = RES_W'(dot4_reg[k]);
                end
            end
        endcase
        sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (res[k] > HI_LIM)
            begin
                clip[k] = HI_LIM;
                sat = 1'b1;
            end
            else if (res[k] < LO_LIM)
            begin
                clip[k] = LO_LIM;
                sat = 1'b1;
            end
            else
            begin
                clip[k] = res[k];
            end
        end
        result_next.result_first = CB'(clip[0]);
        result_next.result_second = CB'(clip[1]);
        result_next.result_third = CB'(clip[2]);
        result_next.saturated = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= point_valid && !busy;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) result_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cmd1_reg <= point.command;
            vec1_reg <= vec1_next;
        end
        if (en2)
        begin
            cmd2_reg <= cmd1_reg;
            ph2_reg <= ph2_next;
            pl2_reg <= pl2_next;
        end
        if (en3)
        begin
            cmd3_reg <= cmd2_reg;
            sh3_reg <= sh3_next;
            sl3_reg <= sl3_next;
        end
        if (en4)
        begin
            cmd4_reg <= cmd3_reg;
            dot4_reg <= dot4_next;
        end
        if (en5)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

>>> rtl/ecef_local_frame_transform.sv
// Top level of the ECEF / local frame point transform on a WGS84 reference.
// Depends on ecefl_pkg, ecefl_setup and ecefl_datapath.
//
//   channel  | direction | handshake                  | beat
//   ---------+-----------+----------------------------+---------------------------------
//   point    | in        | point_valid / point_stall  | command and three coordinates
//   result   | out       | result_valid / result_stall| three coordinates and saturated
//   cfg      | in        | cfg_write_en               | reference latitude, longitude, height
//
// A point beat can be accepted every cycle while the frame is ready and the pipeline
// is not stalled; its result passes through the stage registers to the output register.
// The datapath is five register stages; stages squeeze out bubbles, so a stalled
// result does not block the stages behind it until they are full.
// After reset and after every configuration write the sequencer rebuilds the
// reference frame (two 30-step CORDIC passes, a 32-step square root, a 63-step
// divider and eleven shared-multiplier operations); point_stall stays high until
// the frame is ready.
// Reset is asynchronous and active low; the configuration registers clear to zero.
module ecef_local_frame_transform (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           point_valid,
    output logic                           point_stall,
    input  ecefl_pkg::point_t              point,
    output logic                           result_valid,
    input  logic                           result_stall,
    output ecefl_pkg::result_t             result,
    input  logic                           cfg_write_en,
    input  logic [1:0]                     cfg_index,
    input  logic [ecefl_pkg::CFG_W-1:0]    cfg_data
);

    logic [ecefl_pkg::CFG_W-1:0] lat_reg, lon_reg, hgt_reg;
    ecefl_pkg::frame_t frame;
    logic busy;

    // Configuration registers. Writes to an index beyond the list are dropped,
    // but still restart the frame sequencer, which is harmless.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= '0;
            lon_reg <= '0;
            hgt_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ecefl_pkg::CFG_REF_LATITUDE:  lat_reg <= cfg_data;
                ecefl_pkg::CFG_REF_LONGITUDE: lon_reg <= cfg_data;
                ecefl_pkg::CFG_REF_HEIGHT:    hgt_reg <= cfg_data;
                default:                      lat_reg <= lat_reg;
            endcase
        end
    end

    // The sequencer reads the registers live; the restart pulse lines up with the
    // write so that the rebuild starts from the new value in the next cycle.
    ecefl_setup u_setup (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (cfg_write_en),
        .ref_latitude  (lat_reg),
        .ref_longitude (lon_reg),
        .ref_height    (hgt_reg),
        .frame         (frame),
        .busy          (busy)
    );

    ecefl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .busy         (busy || cfg_write_en),
        .frame        (frame),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/ecefl_checker.sv
// Port-level checker for the ECEF / local frame transform, bound to the top level.
// Depends on ecefl_pkg and ecef_local_frame_transform.
module ecefl_assertions (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           point_valid,
    input  logic                           point_stall,
    input  ecefl_pkg::point_t              point,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  ecefl_pkg::result_t             result,
    input  logic                           cfg_write_en,
    input  logic [1:0]                     cfg_index,
    input  logic [ecefl_pkg::CFG_W-1:0]    cfg_data
);

    localparam logic signed [ecefl_pkg::COORD_BITS-1:0] MAX_C =
        {1'b0, {(ecefl_pkg::COORD_BITS-1){1'b1}}};
    localparam logic signed [ecefl_pkg::COORD_BITS-1:0] MIN_C =
        {1'b1, {(ecefl_pkg::COORD_BITS-1){1'b0}}};

    // A new reference must be rebuilt before any point is taken.
    a_cfg_blocks_points: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> point_stall)
        else $error("point accepted right after a configuration write");

    // Coming out of reset the frame is not ready yet.
    a_reset_blocks_points: assert property (@(posedge clk)
        !$past(rst_n) |-> point_stall)
        else $error("point accepted right after reset");

    // A saturated result has at least one coordinate at a bound.
    a_saturated_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.result_first == MAX_C || result.result_first == MIN_C ||
             result.result_second == MAX_C || result.result_second == MIN_C ||
             result.result_third == MAX_C || result.result_third == MIN_C))
        else $error("saturated flag without a clipped coordinate");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result beat changed");

endmodule

bind ecef_local_frame_transform ecefl_assertions u_checker (.*);

>>> test/ecefl_checker.sv
`timescale 1ns / 1ps
// Checker for the ECEF / local frame transform: watches the point, result and cfg ports,
// predicts each result in integer arithmetic and compares it with the block's output.
// Depends on ecefl_pkg for the beat types and command codes.
module ecefl_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         point_valid,
    input  logic                         point_stall,
    input  ecefl_pkg::point_t            point,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  ecefl_pkg::result_t           result,
    input  logic                         cfg_write_en,
    input  logic [1:0]                   cfg_index,
    input  logic [ecefl_pkg::CFG_W-1:0]  cfg_data,
    output int                           errors,
    output int                           pending
);
    import ecefl_pkg::*;

    localparam longint HALF_LSB  = 64'sd536870912;
    localparam longint UNIT      = 64'sd1073741824;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam longint COORD_MIN = -COORD_MAX - 64'sd1;
    localparam longint unsigned ECC2 = 64'd460034290;
    localparam longint unsigned AXIS = 64'd6378137000;

    longint atan_tab [0:29];
    logic [31:0] lat_q, lon_q, hgt_q;
    result_t expected_q [$];

    initial
    begin
        atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                     81, 41, 20, 10, 5, 3, 1};
    end

    function automatic longint rnd_q30(input longint prod);
        return (prod + HALF_LSB) >>> 30;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    // CORDIC in rotation mode after folding the angle into the right half plane.
    task automatic sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
        logic signed [31:0] a;
        longint z, x, y, dx, dy;
        bit flip;
        a = ang & ANGLE_MASK;
        z = a;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > UNIT)
        begin
            z = z - 2 * UNIT;
            flip = 1;
        end
        else if (z < -UNIT)
        begin
            z = z + 2 * UNIT;
            flip = 1;
        end
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = clamp_unit(x);
        sn = clamp_unit(y);
    endtask

    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Three-term dot product with Q30 weights, rounded once; split to stay in 64 bits.
    function automatic longint dot_q30(input longint c0, c1, c2, v0, v1, v2);
        longint sh, sl;
        sh = (v0 >>> 20) * c0 + (v1 >>> 20) * c1 + (v2 >>> 20) * c2;
        sl = (v0 & 64'shFFFFF) * c0 + (v1 & 64'sh FFFFF) * c1 + (v2 & 64'shFFFFF) * c2;
        sl = sl + HALF_LSB;
        return (sh + (sl >>> 20)) >>> 10;
    endfunction

    task automatic transform_point(input point_t pt, output result_t res);
        longint sl, cl, so, co, n, h, p, e2n, rx, ry, rz, e, nn, u;
        longint m10, m11, m20, m21, v0, v1, v2, o [3];
        longint unsigned s2, e2s2, w, r;
        bit sat;
        sin_cos(lat_q, sl, cl);
        sin_cos(lon_q, so, co);
        s2 = (longint'(sl * sl) + 64'd536870912) >> 30;
        e2s2 = (ECC2 * s2 + (64'd1 << 35)) >> 36;
        w = 64'd1073741824 - e2s2;
        r = sqrt_floor(w << 30);
        n = ((AXIS << 30) + r / 2) / r;
        h = $signed(hgt_q);
        p = rnd_q30((n + h) * cl);
        rx = rnd_q30(p * co);
        ry = rnd_q30(p * so);
        e2n = (longint'(n) * ECC2 + (64'd1 << 35)) >> 36;
        rz = rnd_q30((n - e2n + h) * sl);
        m10 = -rnd_q30(co * sl);
        m11 = -rnd_q30(so * sl);
        m20 = rnd_q30(co * cl);
        m21 = rnd_q30(so * cl);
        v0 = pt.coord_first;
        v1 = pt.coord_second;
        v2 = pt.coord_third;
        if (pt.command == CMD_ECEF_TO_ENU || pt.command == CMD_ECEF_TO_NED)
        begin
            e  = dot_q30(-so, co, 0, v0 - rx, v1 - ry, v2 - rz);
            nn = dot_q30(m10, m11, cl, v0 - rx, v1 - ry, v2 - rz);
            u  = dot_q30(m20, m21, sl, v0 - rx, v1 - ry, v2 - rz);
            if (pt.command == CMD_ECEF_TO_ENU)
                o = '{e, nn, u};
            else
                // Down is the negated rounded up value, so ties go the other way.
                o = '{nn, e, -u};
        end
        else
        begin
            if (pt.command == CMD_ENU_TO_ECEF)
            begin
                e = v0;
                nn = v1;
                u = v2;
            end
            else
            begin
                e = v1;
                nn = v0;
                u = -v2;
            end
            o[0] = rx + dot_q30(-so, m10, m20, e, nn, u);
            o[1] = ry + dot_q30(co, m11, m21, e, nn, u);
            o[2] = rz + dot_q30(0, cl, sl, e, nn, u);
        end
        sat = 0;
        for (int k = 0; k < 3; k++)
        begin
            if (o[k] > COORD_MAX)
            begin
                o[k] = COORD_MAX;
                sat = 1;
            end
            else if (o[k] < COORD_MIN)
            begin
                o[k] = COORD_MIN;
                sat = 1;
            end
        end
        res.result_first  = o[0][COORD_BITS-1:0];
        res.result_second = o[1][COORD_BITS-1:0];
        res.result_third  = o[2][COORD_BITS-1:0];
        res.saturated     = sat;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want, got;
        if (!rst_n)
        begin
            lat_q <= '0;
            lon_q <= '0;
            hgt_q <= '0;
            errors = 0;
            pending = 0;
            expected_q.delete();
        end
        else
        begin
            if (point_valid && !point_stall)
            begin
                transform_point(point, want);
                expected_q.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                got = result;
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no point waiting for it");
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.result_first !== want.result_first)
                    begin
                        $error("result_first: expected %0d, got %0d",
                               want.result_first, got.result_first);
                        errors++;
                    end
                    if (got.result_second !== want.result_second)
                    begin
                        $error("result_second: expected %0d, got %0d",
                               want.result_second, got.result_second);
                        errors++;
                    end
                    if (got.result_third !== want.result_third)
                    begin
                        $error("result_third: expected %0d, got %0d",
                               want.result_third, got.result_third);
                        errors++;
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, got.saturated);
                        errors++;
                    end
                end
            end
            pending = expected_q.size();
            // Index three is not a register and is dropped.
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_REF_LATITUDE)
                    lat_q <= cfg_data;
                else if (cfg_index == CFG_REF_LONGITUDE)
                    lon_q <= cfg_data;
                else if (cfg_index == CFG_REF_HEIGHT)
                    hgt_q <= cfg_data;
            end
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for ecef_local_frame_transform: clock, reset, reference settings,
// point stimulus and result back pressure. Depends on ecefl_pkg and ecefl_checker.
module tb;
    import ecefl_pkg::*;

    // The cfg index port is two bits wide, so one code names no register.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_POINTS = 75;
    localparam int HOLD_CYCLES = 80;
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic clk;
    logic rst_n;
    logic point_valid;
    logic point_stall;
    point_t point;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic cfg_write_en;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int errors;
    int pending;
    int accepted;
    // Once set, neither side idles any more so the tail of the run goes at full rate.
    bit calm;

    ecef_local_frame_transform dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ecefl_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // The timeout allows for the frame rebuild after each write and is still far beyond
    // even a slow correct run.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Result side back pressure. A single long hold-off, counted here, lets the pipeline
    // fill so the block must stall its point input while points keep being offered.
    initial
    begin
        bit held;
        held = 0;
        result_stall = 0;
        forever
        begin
            @(negedge clk);
            if (!calm && !held && accepted >= 150)
            begin
                held = 1;
                result_stall <= 1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            else
                result_stall <= 0;
        end
    end

    // Offer one point beat and hold it until the block takes it.
    task automatic send_point(input point_t pt);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            point_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        point_valid <= 1;
        point <= pt;
        do
            @(posedge clk);
        while (point_stall);
        accepted++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // Wait for every outstanding result, then let the five pipeline stages empty.
    task automatic drain();
        point_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Equally often full-width values, local offsets, earth-scale ECEF values, or the limits, zero and -1.
    function automatic logic signed [COORD_BITS-1:0] random_coord();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return raw[COORD_BITS-1:0];
            1: return $signed(raw[21:0]);
            2: return $signed(raw[34:0]);
            default:
                case ($urandom_range(0, 3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    default: return -1;
                endcase
        endcase
    endfunction

    function automatic point_t random_point();
        point_t pt;
        pt.command = command_t'($urandom_range(0, 3));
        pt.coord_first = random_coord();
        pt.coord_second = random_coord();
        pt.coord_third = random_coord();
        return pt;
    endfunction

    initial
    begin
        point_t pt;
        longint lat;
        logic [CFG_W-1:0] lon, hgt;
        logic signed [COORD_BITS-1:0] corner [4][3];
        rst_n = 0;
        point_valid = 0;
        point = '0;
        cfg_write_en = 0;
        cfg_index = CFG_REF_LATITUDE;
        cfg_data = '0;
        accepted = 0;
        calm = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;

        // Directed part on the reset reference (equator, prime meridian, zero height):
        // every command at the coordinate limits, zero, mixed signs and a surface point.
        corner[0] = '{C_MAX, C_MAX, C_MAX};
        corner[1] = '{C_MIN, C_MIN, C_MIN};
        corner[2] = '{'0, '0, '0};
        corner[3] = '{C_MAX, C_MIN, -1};
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pt.command = command_t'(c);
                pt.coord_first = corner[k][0];
                pt.coord_second = corner[k][1];
                pt.coord_third = corner[k][2];
                send_point(pt);
            end
            pt.command = command_t'(c);
            pt.coord_first = 40'sd6378137000;
            pt.coord_second = 40'sd1000;
            pt.coord_third = -40'sd2000;
            send_point(pt);
        end
        repeat (60) send_point(random_point());
        drain();

        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            // Pole to pole and both longitude and height limits first, then a latitude
            // past the pole, then random references.
            case (ph)
                1:
                begin
                    lat = 64'sd1073741824;
                    lon = 32'h8000_0000;
                    hgt = 32'h7FFF_FFFF;
                end
                2:
                begin
                    lat = -64'sd1073741824;
                    lon = 32'h7FFF_FFFF;
                    hgt = 32'h8000_0000;
                end
                3:
                begin
                    lat = 64'sd1342177280;
                    lon = $urandom;
                    hgt = $urandom_range(0, 20000000);
                end
                default:
                begin
                    lat = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
                    lon = $urandom;
                    hgt = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 10000000);
                end
            endcase
            write_reg(CFG_REF_LATITUDE, lat[31:0]);
            write_reg(CFG_REF_LONGITUDE, lon);
            write_reg(CFG_REF_HEIGHT, hgt);
            if (ph == 1)
                write_reg(CFG_UNUSED, $urandom);
            cfg_write_en <= 0;
            if (ph == NUM_PHASES - 1)
                calm = 1;
            repeat (PHASE_POINTS) send_point(random_point());
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ecefl_pkg.sv
rtl/ecefl_setup.sv
rtl/ecefl_datapath.sv
rtl/ecef_local_frame_transform.sv
rtl/ecefl_checker.sv
test/ecefl_checker.sv
test/tb.sv
